[hdl/kcl_pkg.sv]
// Shared types, operation codes and status codes for the keyed circular list.
`default_nettype none

package kcl_pkg;

  localparam int KCL_CAPACITY = 16;

  localparam logic [2:0] KIND_APPEND  = 3'd0;
  localparam logic [2:0] KIND_PREPEND = 3'd1;
  localparam logic [2:0] KIND_INSERT  = 3'd2;
  localparam logic [2:0] KIND_DELETE  = 3'd3;
  localparam logic [2:0] KIND_UPDATE  = 3'd4;
  localparam logic [2:0] KIND_LOOKUP  = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_NOKEY     = 3'd2;
  localparam logic [2:0] ST_NOANCHOR  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic        [2:0]  kind;
    logic signed [31:0] item_key;
    logic signed [31:0] anchor_key;
    logic signed [31:0] item_data;
  } in_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] found_data;
    logic        [4:0]  entry_count;
  } out_t;

endpackage

`default_nettype wire

[hdl/kcl_cell.sv]
// One list slot: key, data, link and used flag, plus one stage of the search chain.
`default_nettype none

module kcl_cell #(
  parameter int CAPACITY = kcl_pkg::KCL_CAPACITY,
  parameter int IDX      = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [2*32+2*$clog2(CAPACITY)-1:0] query,
  input  wire logic [6*$clog2(CAPACITY)+99:0]     cmd,
  input  wire logic [7*$clog2(CAPACITY)+37:0]     probe_in,
  output logic      [7*$clog2(CAPACITY)+37:0]     probe_out
);

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] MY_SLOT = IW'(IDX);

  typedef struct packed {
    logic [31:0]   key;
    logic [31:0]   anchor;
    logic [IW-1:0] head;
    logic [IW-1:0] target;
  } query_t;

  typedef struct packed {
    logic          valid;
    logic          key_hit;
    logic [IW-1:0] key_slot;
    logic [IW-1:0] key_next;
    logic [31:0]   key_data;
    logic          anc_hit;
    logic [IW-1:0] anc_slot;
    logic [IW-1:0] anc_next;
    logic          free_hit;
    logic [IW-1:0] free_slot;
    logic          tail_hit;
    logic [IW-1:0] tail_slot;
    logic          pred_hit;
    logic [IW-1:0] pred_slot;
  } probe_t;

  typedef struct packed {
    logic          fill_en;
    logic [IW-1:0] fill_slot;
    logic [31:0]   fill_key;
    logic [31:0]   fill_data;
    logic [IW-1:0] fill_next;
    logic          link_en;
    logic [IW-1:0] link_slot;
    logic [IW-1:0] link_val;
    logic          drop_en;
    logic [IW-1:0] drop_slot;
    logic          data_en;
    logic [IW-1:0] data_slot;
    logic [31:0]   data_val;
  } cmd_t;

  query_t q;
  cmd_t   c;
  probe_t pin;
  probe_t pnext;
  probe_t probe;

  logic [31:0]   key;
  logic [31:0]   data;
  logic [IW-1:0] nxt;
  logic          used;

  assign q         = query_t'(query);
  assign c         = cmd_t'(cmd);
  assign pin       = probe_t'(probe_in);
  assign probe_out = probe;

  always_comb begin
    pnext = pin;
    if (!pin.key_hit && used && key == q.key) begin
      pnext.key_hit  = 1'b1;
      pnext.key_slot = MY_SLOT;
      pnext.key_next = nxt;
      pnext.key_data = data;
    end
    if (!pin.anc_hit && used && key == q.anchor) begin
      pnext.anc_hit  = 1'b1;
      pnext.anc_slot = MY_SLOT;
      pnext.anc_next = nxt;
    end
    if (!pin.free_hit && !used) begin
      pnext.free_hit  = 1'b1;
      pnext.free_slot = MY_SLOT;
    end
    if (!pin.tail_hit && used && nxt == q.head) begin
      pnext.tail_hit  = 1'b1;
      pnext.tail_slot = MY_SLOT;
    end
    if (!pin.pred_hit && used && nxt == q.target) begin
      pnext.pred_hit  = 1'b1;
      pnext.pred_slot = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    probe.key_hit   <= pnext.key_hit;
    probe.key_slot  <= pnext.key_slot;
    probe.key_next  <= pnext.key_next;
    probe.key_data  <= pnext.key_data;
    probe.anc_hit   <= pnext.anc_hit;
    probe.anc_slot  <= pnext.anc_slot;
    probe.anc_next  <= pnext.anc_next;
    probe.free_hit  <= pnext.free_hit;
    probe.free_slot <= pnext.free_slot;
    probe.tail_hit  <= pnext.tail_hit;
    probe.tail_slot <= pnext.tail_slot;
    probe.pred_hit  <= pnext.pred_hit;
    probe.pred_slot <= pnext.pred_slot;
    if (c.fill_en && c.fill_slot == MY_SLOT) begin
      key  <= c.fill_key;
      data <= c.fill_data;
      nxt  <= c.fill_next;
    end
    if (c.link_en && c.link_slot == MY_SLOT) begin
      nxt <= c.link_val;
    end
    if (c.data_en && c.data_slot == MY_SLOT) begin
      data <= c.data_val;
    end
    if (rst) begin
      probe.valid <= 1'b0;
      used        <= 1'b0;
    end else begin
      probe.valid <= pin.valid;
      if (c.fill_en && c.fill_slot == MY_SLOT) begin
        used <= 1'b1;
      end
      if (c.drop_en && c.drop_slot == MY_SLOT) begin
        used <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/kcl_ctrl.sv]
// Sequencer: launches search passes down the cell chain, commits writes, returns results.
`default_nettype none

module kcl_ctrl #(
  parameter int CAPACITY = kcl_pkg::KCL_CAPACITY
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire kcl_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output kcl_pkg::out_t     out_data,
  output logic [2*32+2*$clog2(CAPACITY)-1:0] query,
  output logic [6*$clog2(CAPACITY)+99:0]     cmd,
  output logic [7*$clog2(CAPACITY)+37:0]     launch,
  input  wire logic [7*$clog2(CAPACITY)+37:0] result
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [31:0]   key;
    logic [31:0]   anchor;
    logic [IW-1:0] head;
    logic [IW-1:0] target;
  } query_t;

  typedef struct packed {
    logic          valid;
    logic          key_hit;
    logic [IW-1:0] key_slot;
    logic [IW-1:0] key_next;
    logic [31:0]   key_data;
    logic          anc_hit;
    logic [IW-1:0] anc_slot;
    logic [IW-1:0] anc_next;
    logic          free_hit;
    logic [IW-1:0] free_slot;
    logic          tail_hit;
    logic [IW-1:0] tail_slot;
    logic          pred_hit;
    logic [IW-1:0] pred_slot;
  } probe_t;

  typedef struct packed {
    logic          fill_en;
    logic [IW-1:0] fill_slot;
    logic [31:0]   fill_key;
    logic [31:0]   fill_data;
    logic [IW-1:0] fill_next;
    logic          link_en;
    logic [IW-1:0] link_slot;
    logic [IW-1:0] link_val;
    logic          drop_en;
    logic [IW-1:0] drop_slot;
    logic          data_en;
    logic [IW-1:0] data_slot;
    logic [31:0]   data_val;
  } cmd_t;

  typedef enum logic [1:0] {S_IDLE, S_PASS1, S_PASS2, S_FIN} state_t;

  state_t        state;
  kcl_pkg::in_t  item;
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  probe_t        r1;
  logic [2:0]    pend_status;
  logic [31:0]   pend_found;
  query_t        q;
  cmd_t          c;
  probe_t        l;
  probe_t        res;

  assign query    = q;
  assign cmd      = c;
  assign launch   = l;
  assign res      = probe_t'(result);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      l         <= '0;
      c         <= '0;
      out_valid <= 1'b0;
      head      <= '0;
      count     <= '0;
    end else begin
      l       <= '0;
      c.fill_en <= 1'b0;
      c.link_en <= 1'b0;
      c.drop_en <= 1'b0;
      c.data_en <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item     <= in_data;
            q.key    <= in_data.item_key;
            q.anchor <= in_data.anchor_key;
            q.head   <= head;
            q.target <= '0;
            l.valid  <= 1'b1;
            state    <= S_PASS1;
          end
        end
        S_PASS1: begin
          if (res.valid) begin
            r1          <= res;
            pend_found  <= '0;
            pend_status <= kcl_pkg::ST_OK;
            state       <= S_FIN;
            case (item.kind)
              kcl_pkg::KIND_APPEND, kcl_pkg::KIND_PREPEND: begin
                if (res.key_hit) begin
                  pend_status <= kcl_pkg::ST_DUP;
                end else if (!res.free_hit) begin
                  pend_status <= kcl_pkg::ST_FULL;
                end else begin
                  c.fill_en   <= 1'b1;
                  c.fill_slot <= res.free_slot;
                  c.fill_key  <= item.item_key;
                  c.fill_data <= item.item_data;
                  c.fill_next <= (count == '0) ? res.free_slot : head;
                  if (count != '0) begin
                    c.link_en   <= 1'b1;
                    c.link_slot <= res.tail_slot;
                    c.link_val  <= res.free_slot;
                  end
                  if (count == '0 || item.kind == kcl_pkg::KIND_PREPEND) begin
                    head <= res.free_slot;
                  end
                  count <= count + CW'(1);
                end
              end
              kcl_pkg::KIND_INSERT: begin
                if (!res.anc_hit) begin
                  pend_status <= kcl_pkg::ST_NOANCHOR;
                end else if (res.key_hit) begin
                  pend_status <= kcl_pkg::ST_DUP;
                end else if (!res.free_hit) begin
                  pend_status <= kcl_pkg::ST_FULL;
                end else begin
                  c.fill_en   <= 1'b1;
                  c.fill_slot <= res.free_slot;
                  c.fill_key  <= item.item_key;
                  c.fill_data <= item.item_data;
                  c.fill_next <= res.anc_next;
                  c.link_en   <= 1'b1;
                  c.link_slot <= res.anc_slot;
                  c.link_val  <= res.free_slot;
                  count       <= count + CW'(1);
                end
              end
              kcl_pkg::KIND_DELETE: begin
                if (!res.key_hit) begin
                  pend_status <= kcl_pkg::ST_NOKEY;
                end else if (count <= CW'(1)) begin
                  c.drop_en   <= 1'b1;
                  c.drop_slot <= res.key_slot;
                  head        <= '0;
                  count       <= '0;
                end else begin
                  q.target <= res.key_slot;
                  l.valid  <= 1'b1;
                  state    <= S_PASS2;
                end
              end
              kcl_pkg::KIND_UPDATE: begin
                if (res.key_hit) begin
                  c.data_en   <= 1'b1;
                  c.data_slot <= res.key_slot;
                  c.data_val  <= item.item_data;
                end else begin
                  pend_status <= kcl_pkg::ST_NOKEY;
                end
              end
              kcl_pkg::KIND_LOOKUP: begin
                if (res.key_hit) begin
                  pend_found <= res.key_data;
                end else begin
                  pend_status <= kcl_pkg::ST_NOKEY;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PASS2: begin
          if (res.valid) begin
            c.link_en   <= 1'b1;
            c.link_slot <= res.pred_slot;
            c.link_val  <= r1.key_next;
            c.drop_en   <= 1'b1;
            c.drop_slot <= r1.key_slot;
            if (r1.key_slot == head) begin
              head <= r1.key_next;
            end
            count <= count - CW'(1);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_data.status      <= pend_status;
            out_data.found_data  <= pend_found;
            out_data.entry_count <= 5'(count);
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/keyed_circular_list.sv]
// Keyed circular list: top level joining the sequencer and the chain of slot cells.
//
// Input channel in_valid/in_stall/in_data carries one operation per transaction:
// append, prepend, insert after an anchor key, delete, update or look up by key.
// Output channel out_valid/out_stall/out_data returns exactly one result per
// operation: status, data found by a lookup, and the entry count afterwards.
// Every slot is a cell; a search token walks the row of cells one cell per
// cycle, gathering key, anchor, free-slot, tail and predecessor matches.
// Most operations need one walk of the row of cells; delete of a key in a list
// of two or more entries needs a second walk to find the predecessor. One
// operation is in flight at a time; the next transaction is accepted in the
// cycle after the result has been placed in the output register, even while
// that result is still stalled.
// While out_stall is high the result holds and the next finished result waits.
// After reset the list is empty and the head slot is zero; no clearing pass.
`default_nettype none

module keyed_circular_list #(
  parameter int CAPACITY = kcl_pkg::KCL_CAPACITY
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire kcl_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output kcl_pkg::out_t     out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int QW = 2 * 32 + 2 * IW;
  localparam int CMW = 6 * IW + 100;
  localparam int PW = 7 * IW + 38;

  logic [QW-1:0]  query;
  logic [CMW-1:0] cmd;
  logic [PW-1:0]  chain [CAPACITY+1];

  kcl_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .query     (query),
    .cmd       (cmd),
    .launch    (chain[0]),
    .result    (chain[CAPACITY])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kcl_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .query     (query),
      .cmd       (cmd),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1])
    );
  end

endmodule

`default_nettype wire

[bench/tb_keyed_circular_list.sv]
// Self-checking testbench for the keyed circular list: list operations against a shadow list.
`default_nettype none

module tb_keyed_circular_list;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] data;
  } entry_t;

  typedef struct {
    kcl_pkg::in_t op;
    bit           drain_first;
  } pending_op_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  kcl_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  kcl_pkg::out_t out_data;

  entry_t        shadow_list[$];
  kcl_pkg::out_t expected_results[$];
  pending_op_t   op_queue[$];
  logic signed [31:0] key_pool[24];

  int errors = 0;
  int send_gap = 0;
  int hold_gap = 0;
  bit send_calm = 1'b0;

  keyed_circular_list dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int find_entry(logic signed [31:0] key);
    for (int i = 0; i < shadow_list.size(); i++) begin
      if (shadow_list[i].key == key) return i;
    end
    return -1;
  endfunction

  function automatic kcl_pkg::out_t apply_list_op(kcl_pkg::in_t op);
    kcl_pkg::out_t r;
    entry_t        e;
    int            a;
    int            i;
    r = '0;
    r.status = kcl_pkg::ST_OK;
    e.key = op.item_key;
    e.data = op.item_data;
    case (op.kind)
      kcl_pkg::KIND_APPEND, kcl_pkg::KIND_PREPEND: begin
        if (find_entry(op.item_key) >= 0) r.status = kcl_pkg::ST_DUP;
        else if (shadow_list.size() >= kcl_pkg::KCL_CAPACITY) r.status = kcl_pkg::ST_FULL;
        else if (op.kind == kcl_pkg::KIND_APPEND) shadow_list.push_back(e);
        else shadow_list.push_front(e);
      end
      kcl_pkg::KIND_INSERT: begin
        a = find_entry(op.anchor_key);
        if (a < 0) r.status = kcl_pkg::ST_NOANCHOR;
        else if (find_entry(op.item_key) >= 0) r.status = kcl_pkg::ST_DUP;
        else if (shadow_list.size() >= kcl_pkg::KCL_CAPACITY) r.status = kcl_pkg::ST_FULL;
        else shadow_list.insert(a + 1, e);
      end
      kcl_pkg::KIND_DELETE: begin
        i = find_entry(op.item_key);
        if (i < 0) r.status = kcl_pkg::ST_NOKEY;
        else shadow_list.delete(i);
      end
      kcl_pkg::KIND_UPDATE: begin
        i = find_entry(op.item_key);
        if (i < 0) r.status = kcl_pkg::ST_NOKEY;
        else shadow_list[i].data = op.item_data;
      end
      kcl_pkg::KIND_LOOKUP: begin
        i = find_entry(op.item_key);
        if (i < 0) r.status = kcl_pkg::ST_NOKEY;
        else r.found_data = shadow_list[i].data;
      end
      default: begin
      end
    endcase
    r.entry_count = 5'(shadow_list.size());
    return r;
  endfunction

  function automatic kcl_pkg::in_t make_op(logic [2:0] kind, logic signed [31:0] key,
                                           logic signed [31:0] anchor,
                                           logic signed [31:0] data);
    kcl_pkg::in_t t;
    t.kind = kind;
    t.item_key = key;
    t.anchor_key = anchor;
    t.item_data = data;
    return t;
  endfunction

  task automatic queue_op(kcl_pkg::in_t op, bit drain_first = 1'b0);
    pending_op_t p;
    p.op = op;
    p.drain_first = drain_first;
    op_queue.push_back(p);
  endtask

  function automatic logic signed [31:0] pick_key(int pct_pool);
    if ($urandom_range(0, 99) < pct_pool) return key_pool[$urandom_range(0, 23)];
    return $urandom;
  endfunction

  function automatic bit quiet();
    return (op_queue.size() < 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_list_op(in_data));
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (op_queue.size() > 0 &&
                     !(op_queue[0].drain_first && expected_results.size() > 0)) begin
          in_data <= op_queue[0].op;
          in_valid <= 1'b1;
          op_queue.pop_front();
          if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
          if (!quiet() && !send_calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 14);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    kcl_pkg::out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d found_data %0d entry_count %0d",
                 out_data.status, out_data.found_data, out_data.entry_count);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.found_data !== want.found_data) begin
            $error("found_data: expected %0d, actual %0d", want.found_data,
                   out_data.found_data);
            errors++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   out_data.entry_count);
            errors++;
          end
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_stall <= 1'b1;
      end else if (!quiet() && $urandom_range(0, 9) == 0) begin
        hold_gap = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int          phase_len;
    int          r;
    int          sent;
    bit          grow;
    logic [2:0]  kind;

    queue_op(make_op(kcl_pkg::KIND_LOOKUP, 5, 0, 0));
    queue_op(make_op(kcl_pkg::KIND_DELETE, 5, 0, 0));
    queue_op(make_op(kcl_pkg::KIND_UPDATE, 5, 0, 32'h1234_5678));
    queue_op(make_op(kcl_pkg::KIND_INSERT, 1, 5, 7));
    queue_op(make_op(kcl_pkg::KIND_APPEND, 32'h8000_0000, 0, 32'h7fff_ffff));
    queue_op(make_op(kcl_pkg::KIND_PREPEND, 32'h7fff_ffff, 0, 32'h8000_0000));
    queue_op(make_op(kcl_pkg::KIND_INSERT, 0, 32'h8000_0000, 32'hffff_ffff));
    queue_op(make_op(kcl_pkg::KIND_APPEND, 0, 0, 3));
    queue_op(make_op(kcl_pkg::KIND_PREPEND, 32'h8000_0000, 0, 3));
    queue_op(make_op(kcl_pkg::KIND_INSERT, 32'h7fff_ffff, 0, 3));
    queue_op(make_op(kcl_pkg::KIND_INSERT, 9, 77, 3));
    queue_op(make_op(kcl_pkg::KIND_LOOKUP, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    queue_op(make_op(kcl_pkg::KIND_UPDATE, 0, 0, 32'h5a5a_5a5a));
    queue_op(make_op(kcl_pkg::KIND_LOOKUP, 0, 0, 0));
    queue_op(make_op(3'd6, $urandom, $urandom, $urandom));
    queue_op(make_op(3'd7, $urandom, $urandom, $urandom));
    queue_op(make_op(kcl_pkg::KIND_DELETE, 32'h7fff_ffff, 0, 0));
    queue_op(make_op(kcl_pkg::KIND_DELETE, 0, 0, 0));
    queue_op(make_op(kcl_pkg::KIND_LOOKUP, 32'h8000_0000, 0, 0));
    queue_op(make_op(kcl_pkg::KIND_DELETE, 32'h8000_0000, 0, 0));
    queue_op(make_op(kcl_pkg::KIND_LOOKUP, 32'h8000_0000, 0, 0));

    sent = 0;
    for (int ph = 0; sent < 730; ph++) begin
      if (ph % 4 == 0) begin
        for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 0;
        key_pool[3] = 32'hffff_ffff;
      end
      grow = (ph % 2 == 0);
      phase_len = $urandom_range(30, 60);
      for (int n = 0; n < phase_len; n++) begin
        r = $urandom_range(0, 99);
        if (grow) begin
          if (r < 25) kind = kcl_pkg::KIND_APPEND;
          else if (r < 45) kind = kcl_pkg::KIND_PREPEND;
          else if (r < 65) kind = kcl_pkg::KIND_INSERT;
          else if (r < 75) kind = kcl_pkg::KIND_DELETE;
          else if (r < 85) kind = kcl_pkg::KIND_UPDATE;
          else if (r < 97) kind = kcl_pkg::KIND_LOOKUP;
          else kind = 3'($urandom_range(6, 7));
        end else begin
          if (r < 10) kind = kcl_pkg::KIND_APPEND;
          else if (r < 20) kind = kcl_pkg::KIND_PREPEND;
          else if (r < 30) kind = kcl_pkg::KIND_INSERT;
          else if (r < 70) kind = kcl_pkg::KIND_DELETE;
          else if (r < 82) kind = kcl_pkg::KIND_UPDATE;
          else if (r < 97) kind = kcl_pkg::KIND_LOOKUP;
          else kind = 3'($urandom_range(6, 7));
        end
        queue_op(make_op(kind, pick_key(90), pick_key(85), $urandom),
                 (n == 0 && ph % 5 == 0));
        sent++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * kcl_pkg::KCL_CAPACITY + 10) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
